// ----- rtl/rsum_pkg.sv -----
package rsum_pkg;

  localparam int KEY_W      = 32;
  localparam int RANK_W     = 21;
  localparam int U_W        = 20;
  localparam int TIE_W      = 30;
  localparam int OUT_CNT_W  = 11;
  localparam int ERR_W      = 2;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_DROP  = 2'd2;

  typedef struct packed {
    logic [RANK_W-1:0]    rank_sum_doubled;
    logic [U_W-1:0]       u_doubled;
    logic [TIE_W-1:0]     tie_total;
    logic [OUT_CNT_W-1:0] interest_count;
    logic [OUT_CNT_W-1:0] background_count;
    logic [ERR_W-1:0]     error_code;
  } result_t;

endpackage

// ----- rtl/rsum_ram.sv -----
module rsum_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rsum_queue.sv -----
module rsum_queue #(
  parameter int WIDTH = 23
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             nonempty
);

  logic [WIDTH-1:0] slot [2];
  logic             wp;
  logic             rp;
  logic [1:0]       fill;

  assign full     = (fill == 2'd2);
  assign nonempty = (fill != 2'd0);
  assign dout     = slot[rp];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wp] <= din;
    end
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (pop && nonempty) rp <= ~rp;
      fill <= fill + 2'((push && !full) ? 1 : 0) - 2'((pop && nonempty) ? 1 : 0);
    end
  end

endmodule

// ----- rtl/rsum_front.sv -----
module rsum_front #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                sample_value,
  input  logic                              is_interest,
  input  logic                              last_item,
  output logic                              we,
  output logic [$clog2(MAX_SAMPLES)-1:0]    waddr,
  output logic [32:0]                       wdata,
  output logic                              push,
  output logic [2*$clog2(MAX_SAMPLES+1):0]  job,
  input  logic                              q_full,
  input  logic                              done
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = $clog2(MAX_SAMPLES);

  logic [CW-1:0] count;
  logic [CW-1:0] tally;
  logic          ovf;
  logic          busy;
  logic          acc;
  logic          room;
  logic [CW-1:0] count_next;
  logic [CW-1:0] tally_next;
  logic          ovf_next;

  assign in_ready   = !busy && !q_full;
  assign acc        = in_valid && in_ready;
  assign room       = (count < CW'(MAX_SAMPLES));
  assign we         = acc && room;
  assign waddr      = count[AW-1:0];
  // sign flip makes the key compare unsigned
  assign wdata      = {is_interest, ~sample_value[31], sample_value[30:0]};
  assign count_next = count + CW'(room);
  assign tally_next = tally + CW'(room && is_interest);
  assign ovf_next   = ovf | !room;
  assign push       = acc && last_item;
  assign job        = {ovf_next, tally_next, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      tally <= '0;
      ovf   <= 1'b0;
      busy  <= 1'b0;
    end else begin
      if (acc) begin
        if (last_item) begin
          count <= '0;
          tally <= '0;
          ovf   <= 1'b0;
          busy  <= 1'b1;
        end else begin
          count <= count_next;
          tally <= tally_next;
          ovf   <= ovf_next;
        end
      end
      if (done) busy <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SAMPLES)) else $error("sample count past capacity");
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("accepting while set is being ranked");
  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    push |=> busy) else $error("set handed off without blocking the store");
`endif

endmodule

// ----- rtl/rsum_back.sv -----
module rsum_back #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              job_valid,
  input  logic [2*$clog2(MAX_SAMPLES+1):0]  job,
  output logic                              job_pop,
  output logic [$clog2(MAX_SAMPLES)-1:0]    raddr,
  input  logic [32:0]                       rdata,
  output logic                              done,
  output rsum_pkg::result_t                 res,
  output logic                              out_valid,
  input  logic                              out_ready
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int RW = 2 * CW + 2;
  localparam int XW = RW + 32;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDI  = 3'd1;
  localparam logic [2:0] S_LATI = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_RES  = 3'd6;

  logic [2:0]                st;
  logic [CW-1:0]             n;
  logic [CW-1:0]             n1;
  logic                      ovf;
  logic [CW-1:0]             i;
  logic [CW-1:0]             k;
  logic                      pv;
  logic [31:0]               ki;
  logic                      fi;
  logic [CW-1:0]             less;
  logic [CW-1:0]             eq;
  logic [RW-1:0]             rank2;
  logic [rsum_pkg::TIE_W-1:0] ties;
  logic [2*CW-1:0]           p1;
  logic [2*CW-1:0]           p2;
  logic [2*CW-1:0]           sq;
  logic [RW-1:0]             top;
  logic [RW-1:0]             u2;
  logic                      empty;
  logic                      load;

  assign raddr   = (st == S_SCAN) ? k[AW-1:0] : i[AW-1:0];
  assign job_pop = (st == S_IDLE) && job_valid;
  assign sq      = eq * eq;
  assign top     = {p1, 1'b0} + RW'(p2);
  assign u2      = (top >= rank2) ? top - rank2 : '0;
  assign empty   = (n1 == '0) || (n1 == n);
  assign load    = (st == S_RES) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    unique case (st)
      S_IDLE: if (job_valid) begin
        n     <= job[CW-1:0];
        n1    <= job[2*CW-1:CW];
        ovf   <= job[2*CW];
        i     <= '0;
        rank2 <= '0;
        ties  <= '0;
      end
      S_RDI: ;
      S_LATI: begin
        ki   <= rdata[31:0];
        fi   <= rdata[32];
        k    <= '0;
        pv   <= 1'b0;
        less <= '0;
        eq   <= '0;
      end
      S_SCAN: begin
        // read data trails the address by the RAM's output register
        if (k != n) begin
          k  <= k + CW'(1);
          pv <= 1'b1;
        end else begin
          pv <= 1'b0;
        end
        if (pv) begin
          if (rdata[31:0] < ki) less <= less + CW'(1);
          else if (rdata[31:0] == ki) eq <= eq + CW'(1);
        end
      end
      S_ACC: begin
        // each member of a run of t adds t^2-1
        ties <= ties + rsum_pkg::TIE_W'(XW'(sq) - XW'(1));
        if (fi) rank2 <= rank2 + RW'({less, 1'b0}) + RW'(eq) + RW'(1);
        i <= i + CW'(1);
      end
      S_FIN: begin
        p1 <= n1 * (n - n1);
        p2 <= n1 * (n1 + CW'(1));
      end
      S_RES: ;
      default: ;
    endcase
    if (load) begin
      res.rank_sum_doubled <= empty ? '0 : rsum_pkg::RANK_W'(XW'(rank2));
      res.u_doubled        <= empty ? '0 : rsum_pkg::U_W'(XW'(u2));
      res.tie_total        <= ties;
      res.interest_count   <= rsum_pkg::OUT_CNT_W'(XW'(n1));
      res.background_count <= rsum_pkg::OUT_CNT_W'(XW'(n - n1));
      res.error_code       <= empty ? rsum_pkg::ERR_EMPTY
                            : (ovf ? rsum_pkg::ERR_DROP : rsum_pkg::ERR_OK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= load;
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (st)
        S_IDLE: if (job_valid) st <= S_RDI;
        S_RDI:  st <= S_LATI;
        S_LATI: st <= S_SCAN;
        S_SCAN: if (k == n && !pv) st <= S_ACC;
        S_ACC:  st <= (i == n - CW'(1)) ? S_FIN : S_RDI;
        S_FIN:  st <= S_RES;
        S_RES:  if (load) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    (st == S_SCAN) |-> (i < n)) else $error("rank index past set size");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.error_code == rsum_pkg::ERR_EMPTY) |->
      (res.rank_sum_doubled == '0 && res.u_doubled == '0))
    else $error("empty group with nonzero statistic");
  a_done_after_load: assert property (@(posedge clk) disable iff (rst)
    done |-> out_valid) else $error("store released before result posted");
`endif

endmodule

// ----- rtl/rank_sum_with_ties_unit.sv -----
// Wilcoxon/Mann-Whitney rank-sum unit. Samples load one per cycle into an on-chip
// store of MAX_SAMPLES entries; extra samples are dropped and flagged. The beat with
// last_item set hands the set to the ranking engine, which for each stored sample
// scans all stored samples through one RAM read port. Input stalls while a set is
// being ranked; the result waits in an output register until taken.
module rank_sum_with_ties_unit #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [31:0]                    sample_value,
  input  logic                                  is_interest,
  input  logic                                  last_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [rsum_pkg::RANK_W-1:0]           rank_sum_doubled,
  output logic [rsum_pkg::U_W-1:0]              u_doubled,
  output logic [rsum_pkg::TIE_W-1:0]            tie_total,
  output logic [rsum_pkg::OUT_CNT_W-1:0]        interest_count,
  output logic [rsum_pkg::OUT_CNT_W-1:0]        background_count,
  output logic [rsum_pkg::ERR_W-1:0]            error_code
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int JW = 2 * CW + 1;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [32:0]       wdata;
  logic [AW-1:0]     raddr;
  logic [32:0]       rdata;
  logic              push;
  logic [JW-1:0]     job_in;
  logic [JW-1:0]     job_out;
  logic              q_full;
  logic              q_nonempty;
  logic              pop;
  logic              done;
  rsum_pkg::result_t res;

  rsum_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk, .rst, .in_valid, .in_ready, .sample_value, .is_interest, .last_item,
    .we, .waddr, .wdata, .push, .job(job_in), .q_full, .done
  );

  rsum_queue #(.WIDTH(JW)) u_queue (
    .clk, .rst, .push, .din(job_in), .full(q_full), .pop,
    .dout(job_out), .nonempty(q_nonempty)
  );

  rsum_ram #(.WIDTH(33), .DEPTH(MAX_SAMPLES)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  rsum_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk, .rst, .job_valid(q_nonempty), .job(job_out), .job_pop(pop),
    .raddr, .rdata, .done, .res, .out_valid, .out_ready
  );

  assign rank_sum_doubled = res.rank_sum_doubled;
  assign u_doubled        = res.u_doubled;
  assign tie_total        = res.tie_total;
  assign interest_count   = res.interest_count;
  assign background_count = res.background_count;
  assign error_code       = res.error_code;

endmodule
